/* design/assert_macros.svh */
// Assertion macros used by the envelope brightness top-level design file.
// Expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define AEB_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication form: antecedent then consequent on the next clock.
`define AEB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/aeb_pkg.sv */
// Package for the audio envelope brightness block: widths, reset values
// and constant-division factors. No dependencies.
package aeb_pkg;

	localparam int unsigned AEB_LEVEL_W   = 16;
	localparam int unsigned AEB_TICK_W    = 8;
	localparam int unsigned AEB_DRIVE_W   = 17;
	localparam int unsigned AEB_PROD_W    = 2 * AEB_LEVEL_W;
	localparam int unsigned AEB_MAX_TICKS = 255;

	localparam logic [AEB_LEVEL_W-1:0] AEB_MIX_GAIN_RST = 16'd6554;

	// Smoothing divisors: low envelope weight 120/121, high envelope 50/51.
	localparam logic [AEB_LEVEL_W:0] AEB_LOW_DIV  = 17'd121;
	localparam logic [AEB_LEVEL_W:0] AEB_HIGH_DIV = 17'd51;

	// floor(m/d) = (m * ceil(2^24/d)) >> 24, exact for m < 2^17.
	localparam int unsigned AEB_RECIP_SHIFT = 24;
	localparam int unsigned AEB_RECIP_W     = 19;
	localparam logic [AEB_RECIP_W-1:0] AEB_LOW_RECIP  = 19'd138655;
	localparam logic [AEB_RECIP_W-1:0] AEB_HIGH_RECIP = 19'd328966;

endpackage

/* design/aeb_mul.sv */
// Shared 16x16 unsigned multiplier with a registered product.
// Depends on aeb_pkg.
module aeb_mul import aeb_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic [AEB_LEVEL_W-1:0] a,
	input  logic [AEB_LEVEL_W-1:0] b,
	output logic [AEB_PROD_W-1:0]  p
);

	logic [AEB_PROD_W-1:0] p_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= AEB_PROD_W'(a) * AEB_PROD_W'(b);
		end
	end

	assign p = p_s1;

endmodule

/* design/aeb_step.sv */
// One smoothing step: env' = floor((w*env + x) / (w+1)), computed as
// env + floor((x - env)/(w+1)) with a reciprocal multiply. Depends on aeb_pkg.
module aeb_step import aeb_pkg::*; (
	input  logic                   sel_high,
	input  logic [AEB_LEVEL_W-1:0] env,
	input  logic [AEB_LEVEL_W-1:0] x,
	output logic [AEB_LEVEL_W-1:0] env_next
);

	localparam int unsigned MW = AEB_LEVEL_W + 1;
	localparam int unsigned PW = MW + AEB_RECIP_W;

	logic                   rising;
	logic [MW-1:0]          div;
	logic [AEB_RECIP_W-1:0] recip;
	logic [MW-1:0]          mag;
	logic [PW-1:0]          prod;
	logic [AEB_LEVEL_W-1:0] quot;

	always_comb begin
		rising = (x >= env);
		div    = sel_high ? AEB_HIGH_DIV : AEB_LOW_DIV;
		recip  = sel_high ? AEB_HIGH_RECIP : AEB_LOW_RECIP;
		// negative side: floor(-m/d) = -floor((m + d - 1)/d)
		if (rising) begin
			mag = MW'(x - env);
		end else begin
			mag = MW'(env - x) + div - MW'(1);
		end
		prod = PW'(mag) * PW'(recip);
		quot = AEB_LEVEL_W'(prod >> AEB_RECIP_SHIFT);
		if (rising) begin
			env_next = env + quot;
		end else begin
			env_next = env - quot;
		end
	end

endmodule

/* design/audio_envelope_brightness.sv */
// Channel   Dir  Width  Contents
// s_axis    in   40     low_level, high_level, elapsed_ticks
// m_axis    out  24     drive_level
// cfg       in   16     mix_gain
//
// Each item is squared, smoothed for min(elapsed_ticks, MAX_TICKS) ticks,
// attack-clamped and mixed. The step unit runs each tick as one low and one
// high envelope step. The multiplier serves squaring and mixing.
// arst_n clears envelopes and handshakes and loads the default gain. A result
// waits in the output register; the next item is taken while it waits, and that
// item's last cycle holds until the register empties.
// Top level of the envelope brightness block. Depends on aeb_pkg,
// aeb_mul, aeb_step and assert_macros.svh.
`include "assert_macros.svh"

module audio_envelope_brightness import aeb_pkg::*; #(
	parameter int unsigned MAX_TICKS = AEB_MAX_TICKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // low_level[15:0], high_level[31:16], elapsed_ticks[39:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // drive_level[16:0], zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data       // mix_gain
);

	localparam int unsigned TICK_CAP = (MAX_TICKS < 255) ? MAX_TICKS : 255;
	localparam logic [AEB_TICK_W-1:0] TICK_CAP_V = AEB_TICK_W'(TICK_CAP);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_TICK,
		ST_ATTACK,
		ST_MIX,
		ST_FINISH
	} state_t;

	state_t                 state_q;
	logic [AEB_LEVEL_W-1:0] low_q;
	logic [AEB_LEVEL_W-1:0] high_q;
	logic [AEB_TICK_W-1:0]  cnt_q;
	logic                   phase_q;
	logic [AEB_LEVEL_W-1:0] low_env_q;
	logic [AEB_LEVEL_W-1:0] high_env_q;
	logic [AEB_LEVEL_W-1:0] gain_q;
	logic [AEB_LEVEL_W-1:0] big_q;
	logic                   out_valid_q;
	logic [AEB_DRIVE_W-1:0] out_q;

	logic                   in_xfer;
	logic [AEB_TICK_W-1:0]  ticks_in;
	logic [AEB_TICK_W-1:0]  ticks_sat;
	logic                   mul_en;
	logic [AEB_LEVEL_W-1:0] mul_a;
	logic [AEB_LEVEL_W-1:0] mul_b;
	logic [AEB_PROD_W-1:0]  mul_p;
	logic [AEB_LEVEL_W-1:0] sq;
	logic [AEB_LEVEL_W-1:0] step_env;
	logic [AEB_LEVEL_W-1:0] step_x;
	logic [AEB_LEVEL_W-1:0] step_next;
	logic                   low_is_big;
	logic [AEB_LEVEL_W-1:0] small_env;
	logic [AEB_DRIVE_W-1:0] drive;
	logic                   out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign ticks_in      = s_axis_tdata[39:32];
	assign ticks_sat     = (ticks_in > TICK_CAP_V) ? TICK_CAP_V : ticks_in;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(24 - AEB_DRIVE_W){1'b0}}, out_q};
	assign out_free      = !out_valid_q || m_axis_tready;

	// squared level stays in the product register until the mix step
	assign sq = mul_p[AEB_PROD_W-1:AEB_LEVEL_W];

	assign low_is_big = (low_env_q > high_env_q);
	assign small_env  = low_is_big ? high_env_q : low_env_q;
	assign drive      = AEB_DRIVE_W'(big_q) + AEB_DRIVE_W'(sq);

	always_comb begin
		mul_en = (state_q == ST_SQUARE) || (state_q == ST_MIX);
		mul_a  = (state_q == ST_MIX) ? gain_q : low_q;
		mul_b  = (state_q == ST_MIX) ? small_env : low_q;
	end

	assign step_env = phase_q ? high_env_q : low_env_q;
	assign step_x   = phase_q ? high_q : sq;

	aeb_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	aeb_step u_step (
		.sel_high (phase_q),
		.env      (step_env),
		.x        (step_x),
		.env_next (step_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			low_env_q   <= '0;
			high_env_q  <= '0;
			gain_q      <= AEB_MIX_GAIN_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				gain_q <= cfg_data;
			end
			if (out_valid_q && m_axis_tready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q   <= ticks_sat;
						phase_q <= 1'b0;
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					state_q <= ST_TICK;
				end
				ST_TICK: begin
					if (cnt_q == '0) begin
						state_q <= ST_ATTACK;
					end else begin
						if (phase_q) begin
							high_env_q <= step_next;
							cnt_q      <= cnt_q - AEB_TICK_W'(1);
						end else begin
							low_env_q <= step_next;
						end
						phase_q <= !phase_q;
					end
				end
				ST_ATTACK: begin
					if (sq > low_env_q) begin
						low_env_q <= sq;
					end
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			low_q  <= s_axis_tdata[15:0];
			high_q <= s_axis_tdata[31:16];
		end
		if (state_q == ST_MIX) begin
			big_q <= low_is_big ? low_env_q : high_env_q;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q <= drive;
		end
	end

	`AEB_ASSERT_NEXT(a_tick_count_down, (state_q == ST_TICK && cnt_q != '0),
		(cnt_q <= $past(cnt_q)), "tick count grew during smoothing")
	`AEB_ASSERT_NEXT(a_attack_applied, (state_q == ST_ATTACK),
		(low_env_q >= $past(sq)), "low envelope below squared level after attack")
	`AEB_ASSERT_NEXT(a_drive_not_below_big, (state_q == ST_FINISH && out_free),
		(m_axis_tvalid && m_axis_tdata[16:0] >= {1'b0, $past(big_q)}),
		"result below larger envelope")

endmodule
